// ===== hw/rtl/lms_weu_pkg.sv =====
`default_nettype none

package lms_weu_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int COLOR_W  = 24;
  localparam int WEIGHT_W = 32;
  localparam int STEP_W   = 16;
  localparam int D_W      = 25;
  localparam int DELTA_W  = 45;
  localparam int CPROD_W  = SAMPLE_W + COEF_W;
  localparam int CACC_W   = CPROD_W + 4;
  localparam int DPROD_W  = COLOR_W + WEIGHT_W;
  localparam int UPROD_W  = D_W + WEIGHT_W;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 32'sh0100_0000;
  localparam logic [STEP_W-1:0]          STEP_RESET = 16'd655;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic preset;
  } tap_ctrl_t;

  // data model coefficients, q2.14
  function automatic logic signed [COEF_W-1:0] model_coef(input logic [3:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      4'd0:    c = 16'sd16384;
      4'd1:    c = 16'sd13107;
      4'd2:    c = 16'sd13107;
      4'd3:    c = -16'sd11469;
      4'd4:    c = 16'sd9830;
      4'd5:    c = -16'sd8192;
      4'd6:    c = 16'sd6554;
      4'd7:    c = -16'sd4915;
      4'd8:    c = 16'sd3277;
      4'd9:    c = -16'sd1638;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lms_weu_raw_cell.sv =====
`default_nettype none

module lms_weu_raw_cell (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   shift_en,
  input  wire logic                                   rotate_en,
  input  wire logic signed [lms_weu_pkg::SAMPLE_W-1:0] u_left,
  input  wire logic signed [lms_weu_pkg::SAMPLE_W-1:0] u_right,
  output logic signed      [lms_weu_pkg::SAMPLE_W-1:0] u_o
);
  import lms_weu_pkg::*;

  logic signed [SAMPLE_W-1:0] u_r;
  logic signed [SAMPLE_W-1:0] u_nxt;

  always_comb begin
    u_nxt = u_r;
    if (shift_en) begin
      u_nxt = u_left;
    end else if (rotate_en) begin
      u_nxt = u_right;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= '0;
    end else begin
      u_r <= u_nxt;
    end
  end

  assign u_o = u_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lms_weu_tap_cell.sv =====
`default_nettype none

module lms_weu_tap_cell (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire lms_weu_pkg::tap_ctrl_t                 ctrl,
  input  wire logic signed [lms_weu_pkg::COLOR_W-1:0]  x_left,
  input  wire logic signed [lms_weu_pkg::COLOR_W-1:0]  x_right,
  input  wire logic signed [lms_weu_pkg::WEIGHT_W-1:0] w_right,
  input  wire logic signed [lms_weu_pkg::D_W-1:0]      d_right,
  output logic signed      [lms_weu_pkg::COLOR_W-1:0]  x_o,
  output logic signed      [lms_weu_pkg::WEIGHT_W-1:0] w_o,
  output logic signed      [lms_weu_pkg::D_W-1:0]      d_o
);
  import lms_weu_pkg::*;

  logic signed [COLOR_W-1:0]  x_r, x_nxt;
  logic signed [WEIGHT_W-1:0] w_r, w_nxt;
  logic signed [D_W-1:0]      d_r, d_nxt;

  // history shifts, weights stay in place; rotation moves history, weights and d terms around the ring
  always_comb begin
    x_nxt = x_r;
    w_nxt = w_r;
    d_nxt = d_r;
    if (ctrl.shift) begin
      x_nxt = x_left;
    end else if (ctrl.rotate) begin
      x_nxt = x_right;
      w_nxt = w_right;
      d_nxt = d_right;
    end
    if (ctrl.preset) begin
      w_nxt = WEIGHT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      w_r <= WEIGHT_ONE;
      d_r <= '0;
    end else begin
      x_r <= x_nxt;
      w_r <= w_nxt;
      d_r <= d_nxt;
    end
  end

  assign x_o = x_r;
  assign w_o = w_r;
  assign d_o = d_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lms_weu_core.sv =====
`default_nettype none

// LMS weight-error update core. Each input beat carries a white sample and a
// noise sample (tdata) plus new_trial and adapt flags (tuser). The sample is
// colored by a fixed FIR data model and pushed into a TAPS-deep history; with
// adapt set, one output beat gives the first weight-error coefficient before
// the update and the saturated error term x.w + v, and all weights then take
// the LMS step w -= beta*x*e. Raw samples, colored samples and weights live in
// two rings of cells that rotate past the multipliers at the ring heads: one
// rotation for coloring, one with adapt for the inner product, and a multiply
// step and a rotate step per tap for the update. A finished result waits in
// the output register while the next beat is accepted. step_size is written
// through cfg_we/cfg_wdata, by the user only while idle; the core does not
// enforce this.
module lms_weight_error_update_core #(
  parameter int TAPS       = 8,
  parameter int MODEL_TAPS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,   // step_size
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // input_sample, noise_sample
  input  wire logic [1:0]  in_tuser,    // new_trial, adapt
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata    // first_weight, error_term
);
  import lms_weu_pkg::*;

  localparam int CNT_MAX = (TAPS > MODEL_TAPS) ? TAPS : MODEL_TAPS;
  localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int DACC_W  = DPROD_W + $clog2(TAPS);
  localparam int ERRW_W  = DACC_W - 11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COLOR,
    ST_COLOR_DRAIN,
    ST_SHIFT,
    ST_DOT,
    ST_DOT_DRAIN,
    ST_ERR,
    ST_UPD_MUL,
    ST_UPD_ROT,
    ST_EMIT
  } state_t;

  state_t                     state_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [STEP_W-1:0]          step_size_r;
  logic signed [SAMPLE_W-1:0] v_r;
  logic                       new_trial_r;
  logic                       adapt_r;
  logic signed [CPROD_W-1:0]  cprod_r;
  logic signed [CACC_W-1:0]   cacc_r;
  logic signed [DPROD_W-1:0]  dprod_r;
  logic signed [DACC_W-1:0]   dacc_r;
  logic signed [WEIGHT_W-1:0] w0_r;
  logic signed [WEIGHT_W-1:0] err_r;
  logic signed [DELTA_W-1:0]  delta_r;
  logic                       out_valid_r;
  logic [63:0]                out_data_r;

  logic signed [SAMPLE_W-1:0] raw_q [MODEL_TAPS];
  logic signed [COLOR_W-1:0]  x_q   [TAPS];
  logic signed [WEIGHT_W-1:0] w_q   [TAPS];
  logic signed [D_W-1:0]      d_q   [TAPS];

  logic                       in_acc;
  logic                       cnt_last_color;
  logic                       cnt_last_tap;
  logic                       out_free;
  tap_ctrl_t                  tap_ctrl;
  logic signed [CPROD_W-1:0]  cprod;
  logic signed [COLOR_W-1:0]  color_x;
  logic signed [DPROD_W-1:0]  dprod;
  logic signed [40:0]         bx_prod;
  logic signed [D_W-1:0]      d_new;
  logic signed [ERRW_W-1:0]   err_wide;
  logic signed [WEIGHT_W-1:0] err_sat;
  logic signed [UPROD_W-1:0]  uprod;
  logic signed [DELTA_W:0]    w_diff;
  logic signed [WEIGHT_W-1:0] w_upd;
  logic signed [WEIGHT_W-1:0] w_tail;
  logic signed [D_W-1:0]      d_tail;

  assign in_tready      = (state_r == ST_IDLE);
  assign in_acc         = in_tvalid && in_tready;
  assign cnt_last_color = (cnt_r == CNT_W'(MODEL_TAPS - 1));
  assign cnt_last_tap   = (cnt_r == CNT_W'(TAPS - 1));
  assign out_free       = !out_valid_r || out_tready;

  always_comb begin
    tap_ctrl.shift  = (state_r == ST_SHIFT);
    tap_ctrl.preset = (state_r == ST_SHIFT) && new_trial_r;
    tap_ctrl.rotate = (state_r == ST_DOT) || (state_r == ST_UPD_ROT);
  end

  always_comb begin
    cprod    = model_coef(4'(cnt_r)) * raw_q[0];
    color_x  = COLOR_W'($signed(cacc_r[CACC_W-1:14]));
    dprod    = x_q[0] * w_q[0];
    bx_prod  = $signed({1'b0, step_size_r}) * x_q[0];
    d_new    = bx_prod[40:16];
    err_wide = ERRW_W'($signed(dacc_r[DACC_W-1:12])) + ERRW_W'($signed({v_r, 12'b0}));
    if ((&err_wide[ERRW_W-1:WEIGHT_W-1]) || !(|err_wide[ERRW_W-1:WEIGHT_W-1])) begin
      err_sat = err_wide[WEIGHT_W-1:0];
    end else begin
      err_sat = {err_wide[ERRW_W-1], {(WEIGHT_W-1){~err_wide[ERRW_W-1]}}};
    end
    uprod  = d_q[0] * err_r;
    w_diff = (DELTA_W+1)'(w_q[0]) - (DELTA_W+1)'(delta_r);
    if ((&w_diff[DELTA_W:WEIGHT_W-1]) || !(|w_diff[DELTA_W:WEIGHT_W-1])) begin
      w_upd = w_diff[WEIGHT_W-1:0];
    end else begin
      w_upd = {w_diff[DELTA_W], {(WEIGHT_W-1){~w_diff[DELTA_W]}}};
    end
    w_tail = (state_r == ST_UPD_ROT) ? w_upd : w_q[0];
    d_tail = (state_r == ST_DOT) ? d_new : d_q[0];
  end

  for (genvar i = 0; i < MODEL_TAPS; i++) begin : g_raw
    logic signed [SAMPLE_W-1:0] left_s;
    logic signed [SAMPLE_W-1:0] right_s;
    if (i == 0) begin : g_l0
      assign left_s = $signed(in_tdata[SAMPLE_W-1:0]);
    end else begin : g_ln
      assign left_s = raw_q[i-1];
    end
    if (i == MODEL_TAPS - 1) begin : g_rt
      assign right_s = raw_q[0];
    end else begin : g_rn
      assign right_s = raw_q[i+1];
    end
    lms_weu_raw_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (in_acc),
      .rotate_en (state_r == ST_COLOR),
      .u_left    (left_s),
      .u_right   (right_s),
      .u_o       (raw_q[i])
    );
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    logic signed [COLOR_W-1:0]  xl_s;
    logic signed [COLOR_W-1:0]  xr_s;
    logic signed [WEIGHT_W-1:0] wr_s;
    logic signed [D_W-1:0]      dr_s;
    if (i == 0) begin : g_l0
      assign xl_s = color_x;
    end else begin : g_ln
      assign xl_s = x_q[i-1];
    end
    if (i == TAPS - 1) begin : g_rt
      assign xr_s = x_q[0];
      assign wr_s = w_tail;
      assign dr_s = d_tail;
    end else begin : g_rn
      assign xr_s = x_q[i+1];
      assign wr_s = w_q[i+1];
      assign dr_s = d_q[i+1];
    end
    lms_weu_tap_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (tap_ctrl),
      .x_left  (xl_s),
      .x_right (xr_s),
      .w_right (wr_s),
      .d_right (dr_s),
      .x_o     (x_q[i]),
      .w_o     (w_q[i]),
      .d_o     (d_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      step_size_r <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        step_size_r <= cfg_wdata;
      end
      if (out_tready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_acc) begin
            v_r         <= $signed(in_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            new_trial_r <= in_tuser[0];
            adapt_r     <= in_tuser[1];
            state_r     <= ST_COLOR;
          end
        end
        ST_COLOR: begin
          cprod_r <= cprod;
          cacc_r  <= (cnt_r == '0) ? '0 : cacc_r + CACC_W'(cprod_r);
          if (cnt_last_color) begin
            cnt_r   <= '0;
            state_r <= ST_COLOR_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_COLOR_DRAIN: begin
          cacc_r  <= cacc_r + CACC_W'(cprod_r);
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          state_r <= adapt_r ? ST_DOT : ST_IDLE;
        end
        ST_DOT: begin
          dprod_r <= dprod;
          dacc_r  <= (cnt_r == '0) ? '0 : dacc_r + DACC_W'(dprod_r);
          if (cnt_r == '0) begin
            w0_r <= w_q[0];
          end
          if (cnt_last_tap) begin
            cnt_r   <= '0;
            state_r <= ST_DOT_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DOT_DRAIN: begin
          dacc_r  <= dacc_r + DACC_W'(dprod_r);
          state_r <= ST_ERR;
        end
        ST_ERR: begin
          err_r   <= err_sat;
          state_r <= ST_UPD_MUL;
        end
        ST_UPD_MUL: begin
          delta_r <= uprod[UPROD_W-1:12];
          state_r <= ST_UPD_ROT;
        end
        ST_UPD_ROT: begin
          if (cnt_last_tap) begin
            cnt_r   <= '0;
            state_r <= ST_EMIT;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= ST_UPD_MUL;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {err_r, w0_r};
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
